/* rtl/tcnt_pkg.sv */
// Shared types and constants of the tile color novelty table.
// Holds the sequencer state type, operation and register codes, field widths
// and fixed values; used by rtl/tile_color_novelty_table_unit.sv.
package tcnt_pkg;

    localparam int CFG_W   = 8;
    localparam int PIX_W   = 8;
    localparam int DEPTH_W = 12;
    localparam int FRAME_W = 16;
    localparam int COUNT_W = 20;
    localparam int CIDX_W  = 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TILE,
        S_READ,
        S_WRITE,
        S_FIN
    } t_state;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_TILE_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TILE_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ROW_SHIFT   = 2'd2;

    localparam logic [CFG_W-1:0] TILE_WIDTH_RST  = 8'd10;
    localparam logic [CFG_W-1:0] TILE_HEIGHT_RST = 8'd14;
    localparam logic [CFG_W-1:0] ROW_SHIFT_RST   = 8'd0;

    localparam logic [DEPTH_W-1:0] NEVER_SEEN = 12'd4095;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX  = 12'd4094;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 20'hFFFFF;
    localparam logic [FRAME_W-1:0] FRAME_LAST = 16'hFFFF;
    localparam logic [FRAME_W-1:0] FRAME_FIRST = 16'd1;

    // Jobs of the geometry recompute sequence; lane jobs follow JOB_LANES:
    // first the row-zero value of every tiling, then the current-row value.
    localparam int JOB_TILINGS = 0;
    localparam int JOB_ACROSS  = 1;
    localparam int JOB_COLUMN  = 2;
    localparam int JOB_LANES   = 3;

endpackage

/* rtl/tile_color_novelty_table_unit.sv */
// Width-one novelty table over tiled grayscale frames: top level.
// Depends on tcnt_pkg; holds the depth and frame stamp memories.
//
// Usage: pixels of a frame arrive in raster order on the input channel
// (i_valid / o_ready), each with the frame's search depth. A transaction with
// i_operation = clear wipes all tables and counters and yields no result.
// The pixel that carries i_last yields one result transaction on the output
// channel (o_valid / i_ready): novel, equal_seen, feature_count, overflow.
// Each pixel works through its T active tilings (1 to MAX_TABLINGS) one after
// another: one tile multiply, one memory read and, for a tile in range, one
// write-back per tiling, as each of the two tables has a single read port.
// The result sits in an output register; the next pixel is accepted while it
// waits. A last pixel that finishes while the register is still full holds
// until the receiver takes the earlier result.
// Reset, a clear transaction and every 65535th frame start a clearing pass
// over all TABLE_SIZE entries (524288 with default parameters) with o_ready low.
// A configuration write starts a geometry recompute on a shared bit-serial
// divider: (3 + 2*MAX_TABLINGS) jobs, each a load, a VAL_W-bit division and a
// store, also run after reset, with o_ready low.
module tile_color_novelty_table_unit #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 210,
    parameter int GRAY_LEVELS   = 256,
    parameter int MAX_TABLINGS  = 4,
    parameter int MAX_TILES     = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tcnt_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [tcnt_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [tcnt_pkg::PIX_W-1:0]    i_pixel,
    input  logic [tcnt_pkg::DEPTH_W-1:0]  i_node_depth,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_novel,
    output logic                          o_equal_seen,
    output logic [tcnt_pkg::COUNT_W-1:0]  o_feature_count,
    output logic                          o_overflow
);
    import tcnt_pkg::*;

    localparam int TABLE_SIZE = MAX_TABLINGS * MAX_TILES * GRAY_LEVELS;
    localparam int ADDR_W = $clog2(TABLE_SIZE);
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
    localparam int ACR_W  = $clog2(SCREEN_WIDTH + 1);
    localparam int GRAY_W = $clog2(GRAY_LEVELS);
    localparam int LANE_W = (MAX_TABLINGS > 1) ? $clog2(MAX_TABLINGS) : 1;
    localparam int CNT_W  = $clog2(MAX_TABLINGS + 1);
    localparam int TILE_W = $clog2(MAX_TILES);
    localparam int VAL_W  = $clog2(SCREEN_HEIGHT + SCREEN_WIDTH
                                   + (MAX_TABLINGS - 1) * 255 + 256);
    localparam int DCNT_W = $clog2(VAL_W + 1);
    localparam int NJOB   = JOB_LANES + 2 * MAX_TABLINGS;
    localparam int JOB_W  = $clog2(NJOB);
    localparam int PROD_W = VAL_W + ACR_W + 1;

    // configuration
    logic [CFG_W-1:0] r_tile_width, r_tile_height, r_row_shift;
    logic [CFG_W-1:0] tw_eff, th_eff, rs_eff;

    // derived geometry
    logic [CNT_W-1:0] r_num_til;
    logic             r_til_ovf;
    logic [ACR_W-1:0] r_across;
    logic [VAL_W-1:0] r_init_q [MAX_TABLINGS];
    logic [CFG_W-1:0] r_init_r [MAX_TABLINGS];
    logic [VAL_W-1:0] r_cur_q  [MAX_TABLINGS];
    logic [CFG_W-1:0] r_cur_r  [MAX_TABLINGS];

    // recompute sequencer and divider
    logic              r_calc_active, r_div_busy;
    logic [JOB_W-1:0]  r_calc_job;
    logic [DCNT_W-1:0] r_div_cnt;
    logic [VAL_W-1:0]  r_div_quo;
    logic [CFG_W-1:0]  r_div_rem, r_div_dsr;
    logic [VAL_W-1:0]  calc_dividend;
    logic [CFG_W-1:0]  calc_divisor;
    logic [JOB_W-1:0]  job_rel, job_lane;
    logic              job_is_cur;
    logic [LANE_W-1:0] calc_lane;
    logic [CFG_W:0]    div_trial;
    logic              div_ge;
    logic [CFG_W-1:0]  n_div_rem;

    // pixel position
    logic [COL_W-1:0] r_col, r_ctile;
    logic [ROW_W-1:0] r_row;
    logic [CFG_W-1:0] r_col_in;

    // item processing
    t_state             r_state, n_state;
    logic [LANE_W-1:0]  r_lane;
    logic [GRAY_W-1:0]  r_gray;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_last;
    logic [TILE_W-1:0]  r_tile;
    logic               r_tile_ok;
    logic [ADDR_W-1:0]  r_addr;
    logic [FRAME_W-1:0] r_frame;
    logic               r_novel_acc, r_equal_acc, r_ovf_acc;
    logic [COUNT_W-1:0] r_lowered;

    logic [PROD_W-1:0]  tile_prod;
    logic [ADDR_W-1:0]  n_rd_addr;
    logic               more_lanes, out_free, accept, seen, lower, same;
    logic [GRAY_W-1:0]  gray_sat;

    // clearing pass
    logic              r_sweep_active, r_sweep_full;
    logic [ADDR_W-1:0] r_sweep_addr;

    // memories
    logic [DEPTH_W-1:0] r_depth_mem [TABLE_SIZE];
    logic [FRAME_W-1:0] r_stamp_mem [TABLE_SIZE];
    logic [DEPTH_W-1:0] r_rd_depth;
    logic [FRAME_W-1:0] r_rd_stamp;
    logic               depth_we, stamp_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DEPTH_W-1:0] depth_wd;
    logic [FRAME_W-1:0] stamp_wd;

    // output register
    logic               r_out_valid, r_out_novel, r_out_equal, r_out_ovf;
    logic [COUNT_W-1:0] r_out_count;

    assign tw_eff = (r_tile_width  == '0) ? CFG_W'(1) : r_tile_width;
    assign th_eff = (r_tile_height == '0) ? CFG_W'(1) : r_tile_height;
    assign rs_eff = (r_row_shift   == '0) ? CFG_W'(1) : r_row_shift;

    // ---------------- recompute job selection ----------------
    assign job_rel    = r_calc_job - JOB_W'(JOB_LANES);
    assign job_is_cur = job_rel >= JOB_W'(MAX_TABLINGS);
    assign job_lane   = job_is_cur ? job_rel - JOB_W'(MAX_TABLINGS) : job_rel;
    assign calc_lane  = LANE_W'(job_lane);

    always_comb begin
        priority if (r_calc_job == JOB_W'(JOB_TILINGS)) begin
            calc_dividend = VAL_W'(th_eff) + VAL_W'(rs_eff) - VAL_W'(1);
            calc_divisor  = rs_eff;
        end else if (r_calc_job == JOB_W'(JOB_ACROSS)) begin
            calc_dividend = VAL_W'(SCREEN_WIDTH) + VAL_W'(tw_eff) - VAL_W'(1);
            calc_divisor  = tw_eff;
        end else if (r_calc_job == JOB_W'(JOB_COLUMN)) begin
            calc_dividend = VAL_W'(r_col);
            calc_divisor  = tw_eff;
        end else begin
            calc_dividend = VAL_W'(calc_lane) * VAL_W'(r_row_shift)
                            + (job_is_cur ? VAL_W'(r_row) : VAL_W'(0));
            calc_divisor  = th_eff;
        end
    end

    // one quotient bit per cycle
    assign div_trial = {r_div_rem, r_div_quo[VAL_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_div_dsr};
    assign n_div_rem = div_ge ? CFG_W'(div_trial - {1'b0, r_div_dsr})
                              : div_trial[CFG_W-1:0];

    // ---------------- item datapath helpers ----------------
    assign o_ready    = (r_state == S_IDLE) && !r_sweep_active && !r_calc_active;
    assign accept     = i_valid && o_ready;
    assign out_free   = !r_out_valid || i_ready;
    assign more_lanes = (CNT_W'(r_lane) + CNT_W'(1)) < r_num_til;

    assign gray_sat = ({1'b0, i_pixel} >= 9'(GRAY_LEVELS))
                      ? GRAY_W'(GRAY_LEVELS - 1) : GRAY_W'(i_pixel);

    assign tile_prod = PROD_W'(r_cur_q[r_lane]) * PROD_W'(r_across)
                       + PROD_W'(r_ctile);

    assign n_rd_addr = (ADDR_W'(r_lane) * ADDR_W'(MAX_TILES) + ADDR_W'(r_tile))
                       * ADDR_W'(GRAY_LEVELS) + ADDR_W'(r_gray);

    assign seen  = (r_rd_stamp == r_frame);
    assign lower = !seen && (r_rd_depth > r_depth);
    assign same  = !seen && (r_rd_depth == r_depth);

    // ---------------- memory write ports ----------------
    assign depth_we = (r_sweep_active && r_sweep_full) || ((r_state == S_WRITE) && lower);
    assign stamp_we = r_sweep_active || ((r_state == S_WRITE) && !seen);
    assign wr_addr  = r_sweep_active ? r_sweep_addr : r_addr;
    assign depth_wd = r_sweep_active ? NEVER_SEEN : r_depth;
    assign stamp_wd = r_sweep_active ? '0 : r_frame;

    always_ff @(posedge i_clk) begin
        if (depth_we) begin
            r_depth_mem[wr_addr] <= depth_wd;
        end
        r_rd_depth <= r_depth_mem[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stamp_we) begin
            r_stamp_mem[wr_addr] <= stamp_wd;
        end
        r_rd_stamp <= r_stamp_mem[n_rd_addr];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_operation != OP_CLEAR) begin
                    n_state = S_TILE;
                end
            end
            S_TILE: begin
                n_state = S_READ;
            end
            S_READ: begin
                if (r_tile_ok) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = more_lanes ? S_TILE : S_FIN;
                end
            end
            S_WRITE: begin
                n_state = more_lanes ? S_TILE : S_FIN;
            end
            S_FIN: begin
                if (!r_last || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_gray  <= gray_sat;
            r_depth <= (i_node_depth == NEVER_SEEN) ? DEPTH_MAX : i_node_depth;
            r_last  <= i_last;
        end
        if (r_state == S_TILE) begin
            r_tile    <= TILE_W'(tile_prod);
            r_tile_ok <= tile_prod < PROD_W'(MAX_TILES);
        end
        if (r_state == S_READ) begin
            r_addr <= n_rd_addr;
        end
    end

    // control, position, geometry and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width   <= TILE_WIDTH_RST;
            r_tile_height  <= TILE_HEIGHT_RST;
            r_row_shift    <= ROW_SHIFT_RST;
            r_num_til      <= CNT_W'(1);
            r_til_ovf      <= 1'b0;
            r_across       <= '0;
            r_calc_active  <= 1'b1;
            r_div_busy     <= 1'b0;
            r_calc_job     <= '0;
            r_div_cnt      <= '0;
            r_col          <= '0;
            r_ctile        <= '0;
            r_col_in       <= '0;
            r_row          <= '0;
            r_lane         <= '0;
            r_frame        <= FRAME_FIRST;
            r_novel_acc    <= 1'b0;
            r_equal_acc    <= 1'b0;
            r_ovf_acc      <= 1'b0;
            r_lowered      <= '0;
            r_sweep_active <= 1'b1;
            r_sweep_full   <= 1'b1;
            r_sweep_addr   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            // clearing pass
            if (r_sweep_active) begin
                if (r_sweep_addr == ADDR_W'(TABLE_SIZE - 1)) begin
                    r_sweep_active <= 1'b0;
                end else begin
                    r_sweep_addr <= r_sweep_addr + ADDR_W'(1);
                end
            end

            // geometry recompute; a configuration write restarts it
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TILE_WIDTH:  r_tile_width  <= i_cfg_data;
                    CFG_TILE_HEIGHT: r_tile_height <= i_cfg_data;
                    CFG_ROW_SHIFT:   r_row_shift   <= i_cfg_data;
                    default: ;
                endcase
                r_calc_active <= 1'b1;
                r_calc_job    <= '0;
                r_div_busy    <= 1'b0;
            end else if (r_calc_active) begin
                if (!r_div_busy) begin
                    r_div_quo  <= calc_dividend;
                    r_div_dsr  <= calc_divisor;
                    r_div_rem  <= '0;
                    r_div_cnt  <= DCNT_W'(VAL_W);
                    r_div_busy <= 1'b1;
                end else if (r_div_cnt != '0) begin
                    r_div_quo <= {r_div_quo[VAL_W-2:0], div_ge};
                    r_div_rem <= n_div_rem;
                    r_div_cnt <= r_div_cnt - DCNT_W'(1);
                end else begin
                    priority if (r_calc_job == JOB_W'(JOB_TILINGS)) begin
                        if (r_row_shift == '0) begin
                            r_num_til <= CNT_W'(1);
                            r_til_ovf <= 1'b0;
                        end else if (r_div_quo > VAL_W'(MAX_TABLINGS)) begin
                            r_num_til <= CNT_W'(MAX_TABLINGS);
                            r_til_ovf <= 1'b1;
                        end else begin
                            r_num_til <= CNT_W'(r_div_quo);
                            r_til_ovf <= 1'b0;
                        end
                    end else if (r_calc_job == JOB_W'(JOB_ACROSS)) begin
                        r_across <= ACR_W'(r_div_quo);
                    end else if (r_calc_job == JOB_W'(JOB_COLUMN)) begin
                        r_ctile  <= COL_W'(r_div_quo);
                        r_col_in <= r_div_rem;
                    end else if (job_is_cur) begin
                        r_cur_q[calc_lane] <= r_div_quo;
                        r_cur_r[calc_lane] <= r_div_rem;
                    end else begin
                        r_init_q[calc_lane] <= r_div_quo;
                        r_init_r[calc_lane] <= r_div_rem;
                    end
                    r_div_busy <= 1'b0;
                    if (r_calc_job == JOB_W'(NJOB - 1)) begin
                        r_calc_active <= 1'b0;
                    end else begin
                        r_calc_job <= r_calc_job + JOB_W'(1);
                    end
                end
            end

            // output register: drop a taken result unless a new one loads now
            if (i_ready && !(r_state == S_FIN && r_last)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_operation == OP_CLEAR) begin
                        r_frame        <= FRAME_FIRST;
                        r_novel_acc    <= 1'b0;
                        r_equal_acc    <= 1'b0;
                        r_ovf_acc      <= 1'b0;
                        r_lowered      <= '0;
                        r_col          <= '0;
                        r_ctile        <= '0;
                        r_col_in       <= '0;
                        r_row          <= '0;
                        for (int i = 0; i < MAX_TABLINGS; i++) begin
                            r_cur_q[i] <= r_init_q[i];
                            r_cur_r[i] <= r_init_r[i];
                        end
                        r_sweep_active <= 1'b1;
                        r_sweep_full   <= 1'b1;
                        r_sweep_addr   <= '0;
                    end else if (accept) begin
                        r_lane <= '0;
                        if (r_til_ovf) begin
                            r_ovf_acc <= 1'b1;
                        end
                    end
                end
                S_TILE: ;
                S_READ: begin
                    if (!r_tile_ok) begin
                        r_ovf_acc <= 1'b1;
                        r_lane    <= r_lane + LANE_W'(1);
                    end
                end
                S_WRITE: begin
                    if (same) begin
                        r_equal_acc <= 1'b1;
                    end
                    if (lower) begin
                        r_novel_acc <= 1'b1;
                        if (r_lowered != COUNT_MAX) begin
                            r_lowered <= r_lowered + COUNT_W'(1);
                        end
                    end
                    r_lane <= r_lane + LANE_W'(1);
                end
                S_FIN: begin
                    if (r_last && out_free) begin
                        // deliver the frame result, then rewind for the next frame
                        r_out_valid <= 1'b1;
                        r_out_novel <= r_novel_acc;
                        r_out_equal <= r_equal_acc;
                        r_out_ovf   <= r_ovf_acc;
                        r_out_count <= r_lowered;
                        r_novel_acc <= 1'b0;
                        r_equal_acc <= 1'b0;
                        r_ovf_acc   <= 1'b0;
                        r_col       <= '0;
                        r_ctile     <= '0;
                        r_col_in    <= '0;
                        r_row       <= '0;
                        for (int i = 0; i < MAX_TABLINGS; i++) begin
                            r_cur_q[i] <= r_init_q[i];
                            r_cur_r[i] <= r_init_r[i];
                        end
                        if (r_frame == FRAME_LAST) begin
                            r_frame        <= FRAME_FIRST;
                            r_sweep_active <= 1'b1;
                            r_sweep_full   <= 1'b0;
                            r_sweep_addr   <= '0;
                        end else begin
                            r_frame <= r_frame + FRAME_W'(1);
                        end
                    end else if (!r_last) begin
                        // advance raster position and the per-tiling row tiles
                        if (r_col == COL_W'(SCREEN_WIDTH - 1)) begin
                            r_col    <= '0;
                            r_ctile  <= '0;
                            r_col_in <= '0;
                            if (r_row == ROW_W'(SCREEN_HEIGHT - 1)) begin
                                r_row <= '0;
                                for (int i = 0; i < MAX_TABLINGS; i++) begin
                                    r_cur_q[i] <= r_init_q[i];
                                    r_cur_r[i] <= r_init_r[i];
                                end
                            end else begin
                                r_row <= r_row + ROW_W'(1);
                                for (int i = 0; i < MAX_TABLINGS; i++) begin
                                    if ({1'b0, r_cur_r[i]} + 9'd1 == {1'b0, th_eff}) begin
                                        r_cur_r[i] <= '0;
                                        r_cur_q[i] <= r_cur_q[i] + VAL_W'(1);
                                    end else begin
                                        r_cur_r[i] <= r_cur_r[i] + CFG_W'(1);
                                    end
                                end
                            end
                        end else begin
                            r_col <= r_col + COL_W'(1);
                            if ({1'b0, r_col_in} + 9'd1 == {1'b0, tw_eff}) begin
                                r_col_in <= '0;
                                r_ctile  <= r_ctile + COL_W'(1);
                            end else begin
                                r_col_in <= r_col_in + CFG_W'(1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_novel         = r_out_novel;
    assign o_equal_seen    = r_out_equal;
    assign o_feature_count = r_out_count;
    assign o_overflow      = r_out_ovf;

    // ---------------- assertions ----------------
    a_sweep_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep_active |-> (r_state == S_IDLE && !o_ready))
        else $error("clearing pass overlaps item processing");

    a_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ($past(r_state) == S_READ))
        else $error("write-back without a preceding table read");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_lowered >= $past(r_lowered)))
        else $error("feature count dropped during a pixel");

    a_frame_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame != '0)
        else $error("frame number reached the cleared stamp value");

    a_tilings_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_num_til != '0) && (r_num_til <= CNT_W'(MAX_TABLINGS)))
        else $error("active tiling count out of range");

endmodule

/* dv/tcnt_scoreboard.sv */
// Checker for the tile color novelty table: watches the pixel, result and
// register channels, predicts each frame result and compares it field by field.
// Depends on tcnt_pkg for widths, codes and fixed values.
module tcnt_scoreboard #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 210,
    parameter int GRAY_LEVELS   = 256,
    parameter int MAX_TABLINGS  = 4,
    parameter int MAX_TILES     = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tcnt_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [tcnt_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic                          i_operation,
    input  logic [tcnt_pkg::PIX_W-1:0]    i_pixel,
    input  logic [tcnt_pkg::DEPTH_W-1:0]  i_node_depth,
    input  logic                          i_last,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic                          i_novel,
    input  logic                          i_equal_seen,
    input  logic [tcnt_pkg::COUNT_W-1:0]  i_feature_count,
    input  logic                          i_overflow,
    output int                            o_mismatches,
    output int                            o_pending
);
    import tcnt_pkg::*;

    typedef struct packed {
        logic               novel;
        logic               equal_seen;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } t_frame_result;

    logic [CFG_W-1:0]   tile_w, tile_h, shift;
    logic [DEPTH_W-1:0] least_depth [int unsigned];
    logic [FRAME_W-1:0] visit_stamp [int unsigned];
    logic [FRAME_W-1:0] frame_no;
    int unsigned        col, row;
    logic               novel_acc, equal_acc, ovf_acc;
    logic [COUNT_W-1:0] lowered;
    t_frame_result      frame_results_q [$];
    int                 mismatches = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = frame_results_q.size();

    function automatic void wipe_tables();
        least_depth.delete();
        visit_stamp.delete();
        frame_no  = FRAME_FIRST;
        col       = 0;
        row       = 0;
        novel_acc = 1'b0;
        equal_acc = 1'b0;
        ovf_acc   = 1'b0;
        lowered   = '0;
    endfunction

    // Examine one entry at most once per frame; absent entries are never seen.
    function automatic void visit_entry(int unsigned addr, logic [DEPTH_W-1:0] depth);
        logic [DEPTH_W-1:0] stored;
        if (visit_stamp.exists(addr) && visit_stamp[addr] == frame_no) return;
        visit_stamp[addr] = frame_no;
        stored = least_depth.exists(addr) ? least_depth[addr] : NEVER_SEEN;
        if (stored == depth) equal_acc = 1'b1;
        if (stored > depth) begin
            least_depth[addr] = depth;
            novel_acc = 1'b1;
            if (lowered != COUNT_MAX) lowered = lowered + 1'b1;
        end
    endfunction

    function automatic void predict_pixel(logic [PIX_W-1:0] gray_in,
                                          logic [DEPTH_W-1:0] depth_in, logic last);
        int unsigned        tw, th, tilings, across, ctile, rtile, tile, gray;
        logic [DEPTH_W-1:0] depth;
        t_frame_result      res;
        depth = (depth_in > DEPTH_MAX) ? DEPTH_MAX : depth_in;
        gray = (gray_in >= GRAY_LEVELS) ? GRAY_LEVELS - 1 : gray_in;
        tw = (tile_w == 0) ? 1 : tile_w;
        th = (tile_h == 0) ? 1 : tile_h;
        tilings = (shift != 0) ? (th + shift - 1) / shift : 1;
        across = (SCREEN_WIDTH + tw - 1) / tw;
        ctile = col / tw;
        for (int unsigned d = 0; d < tilings; d++) begin
            if (d >= MAX_TABLINGS) begin
                ovf_acc = 1'b1;
                break;
            end
            rtile = (row + d * shift) / th;
            tile = rtile * across + ctile;
            if (tile >= MAX_TILES) begin
                ovf_acc = 1'b1;
                continue;
            end
            visit_entry((d * MAX_TILES + tile) * GRAY_LEVELS + gray, depth);
        end

        // advance raster position, wrapping an overlong frame
        col++;
        if (col >= SCREEN_WIDTH) begin
            col = 0;
            row++;
            if (row >= SCREEN_HEIGHT) row = 0;
        end

        if (!last) return;
        res.novel      = novel_acc;
        res.equal_seen = equal_acc;
        res.count      = lowered;
        res.overflow   = ovf_acc;
        frame_results_q = {frame_results_q, res};
        novel_acc = 1'b0;
        equal_acc = 1'b0;
        ovf_acc   = 1'b0;
        col       = 0;
        row       = 0;
        if (frame_no == FRAME_LAST) begin
            visit_stamp.delete();
            frame_no = FRAME_FIRST;
        end else begin
            frame_no = frame_no + 1'b1;
        end
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            tile_w = TILE_WIDTH_RST;
            tile_h = TILE_HEIGHT_RST;
            shift  = ROW_SHIFT_RST;
            wipe_tables();
            frame_results_q.delete();
        end else begin
            // results in flight belong to earlier frames: compare before predicting
            if (i_res_valid && i_res_ready) begin
                if (frame_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transaction with no frame pending, %s %0d",
                             $time, "expected none, actual count", i_feature_count);
                end else begin
                    want = frame_results_q.pop_front();
                    check_field("novel", want.novel, i_novel);
                    check_field("equal_seen", want.equal_seen, i_equal_seen);
                    check_field("feature_count", want.count, i_feature_count);
                    check_field("overflow", want.overflow, i_overflow);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TILE_WIDTH:  tile_w = i_cfg_data;
                    CFG_TILE_HEIGHT: tile_h = i_cfg_data;
                    CFG_ROW_SHIFT:   shift  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                if (i_operation == OP_CLEAR) wipe_tables();
                else predict_pixel(i_pixel, i_node_depth, i_last);
            end
        end
    end

endmodule

/* dv/tb_tile_color_novelty_table_unit.sv */
// Testbench top for tile_color_novelty_table_unit: drives pixel frames, clears
// and geometry writes with random idling, and reports the verdict.
// Depends on tcnt_pkg and the checker in dv/tcnt_scoreboard.sv.
module tb_tile_color_novelty_table_unit;
    import tcnt_pkg::*;

    // reset and clear each hold o_ready low for a full table sweep
    localparam int STALL_LIMIT  = 3_000_000;
    localparam int SETTLE_CYCLES = 24;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CIDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_operation;
    logic [PIX_W-1:0]   i_pixel;
    logic [DEPTH_W-1:0] i_node_depth;
    logic               i_last;
    logic               o_valid;
    logic               i_ready;
    logic               o_novel;
    logic               o_equal_seen;
    logic [COUNT_W-1:0] o_feature_count;
    logic               o_overflow;

    int  mismatches;
    int  pending;
    int  quiet_cycles;
    bit  idle_en;

    tile_color_novelty_table_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_pixel         (i_pixel),
        .i_node_depth    (i_node_depth),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_novel         (o_novel),
        .o_equal_seen    (o_equal_seen),
        .o_feature_count (o_feature_count),
        .o_overflow      (o_overflow)
    );

    tcnt_scoreboard u_novelty_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_operation     (i_operation),
        .i_pixel         (i_pixel),
        .i_node_depth    (i_node_depth),
        .i_last          (i_last),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_novel         (o_novel),
        .i_equal_seen    (o_equal_seen),
        .i_feature_count (o_feature_count),
        .i_overflow      (o_overflow),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result receiver: stall in short bursts while idling is enabled
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_en && $urandom_range(0, 6) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input logic op, input logic [PIX_W-1:0] pix,
                             input logic [DEPTH_W-1:0] depth, input logic last);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_pixel      <= pix;
        i_node_depth <= depth;
        i_last       <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Mostly shallow depths so entries get revisited; sometimes never-seen or any.
    function automatic logic [DEPTH_W-1:0] pick_depth();
        case ($urandom_range(0, 9))
            0:       return NEVER_SEEN;
            1:       return DEPTH_W'($urandom_range(0, 4095));
            default: return DEPTH_W'($urandom_range(0, 31));
        endcase
    endfunction

    task automatic send_frame(input int unsigned len, input int unsigned gray_span);
        logic [DEPTH_W-1:0] depth;
        logic [PIX_W-1:0]   pix;
        depth = pick_depth();
        for (int unsigned k = 0; k < len; k++) begin
            pix = ($urandom_range(0, 9) == 0) ? PIX_W'($urandom_range(0, 255))
                                               : PIX_W'($urandom_range(0, gray_span));
            // occasional per-pixel depth noise inside a frame
            send_item(OP_PIXEL, pix, ($urandom_range(0, 9) == 0) ? pick_depth() : depth,
                      k == len - 1);
        end
    endtask

    // Hold off until every frame result is back and the last pixel has retired.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_geometry(input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th,
                                  input logic [CFG_W-1:0] rs);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TILE_WIDTH;
        i_cfg_data  <= tw;
        @(posedge i_clk);
        i_cfg_index <= CFG_TILE_HEIGHT;
        i_cfg_data  <= th;
        @(posedge i_clk);
        i_cfg_index <= CFG_ROW_SHIFT;
        i_cfg_data  <= rs;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th,
                             input logic [CFG_W-1:0] rs, input int frames,
                             input int unsigned max_len);
        drain();
        write_geometry(tw, th, rs);
        repeat (frames) send_frame($urandom_range(1, max_len), 15);
    endtask

    initial begin
        logic [CFG_W-1:0] rnd_h;
        idle_en      = 1'b1;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_TILE_WIDTH;
        i_cfg_data   <= '0;
        i_valid      <= 1'b0;
        i_operation  <= OP_PIXEL;
        i_pixel      <= '0;
        i_node_depth <= '0;
        i_last       <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames at the reset geometry
        send_item(OP_PIXEL, 8'd0, 12'd0, 1'b1);          // fresh entry at depth zero
        send_item(OP_PIXEL, 8'd255, 12'd4095, 1'b1);     // top depth folds to 4094
        send_item(OP_PIXEL, 8'd255, 12'd4094, 1'b1);     // equal hit
        send_item(OP_PIXEL, 8'd7, 12'd5, 1'b0);
        send_item(OP_PIXEL, 8'd7, 12'd5, 1'b1);          // same tile twice: one visit
        send_item(OP_PIXEL, 8'd7, 12'd5, 1'b1);
        send_item(OP_PIXEL, 8'd7, 12'd6, 1'b1);          // deeper: neither flag
        for (int k = 0; k < 11; k++)                     // crosses into the next tile
            send_item(OP_PIXEL, (k % 2) ? 8'hA5 : 8'h5A, (k % 2) ? 12'hAAA : 12'h555,
                      k == 10);
        send_item(OP_PIXEL, 8'd9, 12'd3, 1'b0);
        send_item(OP_CLEAR, 8'h5A, 12'hABC, 1'b1);       // clear mid-frame, last ignored
        send_item(OP_PIXEL, 8'd7, 12'd5, 1'b1);
        send_item(OP_PIXEL, 8'd7, 12'd5, 1'b1);

        run_phase(8'd0, 8'd0, 8'd0, 25, 6);              // zero tile size acts as one
        run_phase(8'd160, 8'd210, 8'd210, 20, 6);
        run_phase(8'd1, 8'd1, 8'd0, 4, 6);
        send_frame(540, 3);                              // reaches tiles past capacity
        run_phase(8'd3, 8'd14, 8'd1, 25, 6);             // more tilings than lanes
        run_phase(8'd255, 8'd255, 8'd255, 15, 6);
        run_phase(8'd7, 8'd9, 8'd3, 25, 6);
        repeat (3) begin
            rnd_h = CFG_W'($urandom_range(1, 60));
            run_phase(CFG_W'($urandom_range(1, 40)), rnd_h,
                      CFG_W'($urandom_range(0, rnd_h)), 10, 6);
        end

        // closing stretch: no idling on either side
        drain();
        idle_en = 1'b0;
        write_geometry(8'd10, 8'd14, 8'd4);
        repeat (20) send_frame($urandom_range(1, 6), 15);

        drain();
        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/tcnt_pkg.sv
rtl/tile_color_novelty_table_unit.sv
dv/tcnt_scoreboard.sv
dv/tb_tile_color_novelty_table_unit.sv
